// File: hw/rtl/imm_pkg.sv
// Shared types and constants for the integer matrix multiplier.
// No dependencies; imported by imm_cell, integer_matrix_multiply and the testbench.
`timescale 1ns / 1ps

package imm_pkg;

   localparam int MAX_DIM_DEF = 8;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = 3;
   localparam int SIZE_W      = 4;
   localparam int CSR_AW      = 3;
   localparam int CSR_DW      = 32;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // register index (word address) of the size register
   localparam logic REG_MATRIX_SIZE = 1'b0;

   // operand travelling along the cell row
   typedef struct packed {
      logic              valid;
      logic              first;
      logic [IDX_W-1:0]  k;
      logic [DATA_W-1:0] a;
   } link_type;

endpackage

// File: hw/rtl/imm_cell.sv
// One column cell: holds a column of B, multiplies the passing A operand,
// accumulates the dot product and forwards the operand. Depends on imm_pkg.
`timescale 1ns / 1ps

module imm_cell #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [imm_pkg::IDX_W-1:0]  wr_row,
   input  logic [imm_pkg::DATA_W-1:0] wr_data,
   input  imm_pkg::link_type          link_in,
   output imm_pkg::link_type          link_out,
   output logic [imm_pkg::DATA_W-1:0] acc
);
   import imm_pkg::*;

   localparam int KW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [DATA_W-1:0] bcol_ff [MAX_DIM];
   link_type          link_ff;
   logic [DATA_W-1:0] prod_ff;
   logic              pvalid_ff;
   logic              pfirst_ff;
   logic [DATA_W-1:0] acc_ff;
   logic [DATA_W-1:0] acc_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bcol_ff[wr_row[KW-1:0]] <= wr_data;
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (pvalid_ff) begin
         acc_in = pfirst_ff ? prod_ff : acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
         pvalid_ff     <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
         pvalid_ff     <= link_in.valid;
      end
      link_ff.first <= link_in.first;
      link_ff.k     <= link_in.k;
      link_ff.a     <= link_in.a;
      pfirst_ff     <= link_in.first;
      prod_ff       <= link_in.a * bcol_ff[link_in.k[KW-1:0]];
      acc_ff        <= acc_in;
   end

   assign link_out = link_ff;
   assign acc      = acc_ff;

endmodule

// File: hw/rtl/integer_matrix_multiply.sv
// Top level: A store, row/operand sequencer, output register and APB port.
// Depends on imm_pkg and imm_cell.
//
// channel  | dir | handshake              | payload
// req      | in  | req_tvalid/req_tready  | row, col, element (tdata), matrix (tuser), done (tlast)
// rsp      | out | rsp_tvalid/rsp_tready  | row, col, product (tdata), last (tlast)
// csr      | in  | psel/penable, pready=1 | matrix_size at word 0
//
// A load item is taken whenever req_tvalid and req_tready are both high. After the final load each
// of the n rows goes through n A store reads fed into the cell row, a drain through the cells'
// multiply and accumulate stages, then n outputs, one column per cycle while rsp_tready allows.
// Reset is synchronous; no clearing pass. req_tready is low from the final load until the
// last product is in the output register; a stalled output stops the sequencer.
`timescale 1ns / 1ps

module integer_matrix_multiply #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [imm_pkg::REQ_TDATA_W-1:0] req_tdata,  // row_index, col_index, element_value, pad
   input  logic                            req_tuser,  // func
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [imm_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // out_row, out_col, product_value, pad
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [imm_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [imm_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [imm_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);
   import imm_pkg::*;

   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW        = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DRAIN_CYC = MAX_DIM + 2;
   localparam int CNT_W     = $clog2(DRAIN_CYC + 1);

   typedef enum logic [1:0] {S_LOAD, S_ISSUE, S_DRAIN, S_EMIT} state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  row_ff, row_in;
   logic [IDX_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [DATA_W-1:0] rsp_val_ff, rsp_val_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [SIZE_W-1:0] size_ff;

   logic [DATA_W-1:0] a_mem [DEPTH];
   logic [DATA_W-1:0] a_rd_ff;
   logic              issue_valid_ff;
   logic              issue_first_ff;
   logic [IDX_W-1:0]  issue_k_ff;

   logic [IDX_W-1:0]  in_row;
   logic [IDX_W-1:0]  in_col;
   logic [DATA_W-1:0] in_val;
   logic              req_acc;
   logic              in_range;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [SIZE_W-1:0] eff_size;
   logic [IDX_W-1:0]  n_m1;

   link_type          link_w [MAX_DIM+1];
   logic [DATA_W-1:0] acc_w  [MAX_DIM];

   assign in_row  = req_tdata[2:0];
   assign in_col  = req_tdata[5:3];
   assign in_val  = req_tdata[37:6];
   assign req_tready = (state_ff == S_LOAD);
   assign req_acc = req_tvalid && req_tready;
   assign in_range = ({1'b0, in_row} < SIZE_W'(MAX_DIM)) && ({1'b0, in_col} < SIZE_W'(MAX_DIM));
   assign wr_addr = AW'(int'(in_row) * MAX_DIM + int'(in_col));
   assign rd_addr = AW'(int'(row_ff) * MAX_DIM + int'(k_ff));

   always_comb begin
      eff_size = size_ff;
      if (size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(MAX_DIM)) begin
         eff_size = SIZE_W'(MAX_DIM);
      end
   end
   assign n_m1 = IDX_W'(eff_size - SIZE_W'(1));

   // configuration port
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MATRIX_SIZE) begin
         csr_prdata = CSR_DW'(size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == REG_MATRIX_SIZE) begin
         size_ff <= csr_pwdata[SIZE_W-1:0];
      end
   end

   // A store
   always_ff @(posedge clock) begin
      if (req_acc && !req_tuser && in_range) begin
         a_mem[wr_addr] <= in_val;
      end
      if (state_ff == S_ISSUE) begin
         a_rd_ff <= a_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_valid_ff <= 1'b0;
      end else begin
         issue_valid_ff <= (state_ff == S_ISSUE);
      end
      issue_k_ff     <= k_ff;
      issue_first_ff <= (k_ff == '0);
   end

   assign link_w[0].valid = issue_valid_ff;
   assign link_w[0].first = issue_first_ff;
   assign link_w[0].k     = issue_k_ff;
   assign link_w[0].a     = a_rd_ff;

   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      imm_cell #(
         .MAX_DIM (MAX_DIM)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .wr_en    (req_acc && req_tuser && in_range && in_col == IDX_W'(j)),
         .wr_row   (in_row),
         .wr_data  (in_val),
         .link_in  (link_w[j]),
         .link_out (link_w[j+1]),
         .acc      (acc_w[j])
      );
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      k_in         = k_ff;
      col_in       = col_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_LOAD: begin
            if (req_acc && req_tlast) begin
               state_in = S_ISSUE;
               row_in   = '0;
               k_in     = '0;
            end
         end
         S_ISSUE: begin
            k_in = k_ff + IDX_W'(1);
            if (k_ff == n_m1) begin
               state_in = S_DRAIN;
               cnt_in   = '0;
            end
         end
         S_DRAIN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DRAIN_CYC - 1)) begin
               state_in = S_EMIT;
               col_in   = '0;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = row_ff;
               rsp_col_in   = col_ff;
               rsp_val_in   = acc_w[col_ff[KW-1:0]];
               rsp_last_in  = (row_ff == n_m1) && (col_ff == n_m1);
               col_in       = col_ff + IDX_W'(1);
               if (col_ff == n_m1) begin
                  col_in = '0;
                  if (row_ff == n_m1) begin
                     state_in = S_LOAD;
                  end else begin
                     state_in = S_ISSUE;
                     row_in   = row_ff + IDX_W'(1);
                     k_in     = '0;
                  end
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         row_ff       <= '0;
         k_ff         <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         k_ff         <= k_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_val_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   a_final_load_starts: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_tlast |=> state_ff == S_ISSUE && row_ff == '0 && k_ff == '0)
      else $error("final load did not start row 0");

   a_issue_in_size: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ISSUE |-> k_ff <= n_m1 && row_ff <= n_m1)
      else $error("operand index beyond active size");

   a_emit_in_size: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> col_ff <= n_m1 && row_ff <= n_m1)
      else $error("output index beyond active size");

   a_operand_source: assert property (@(posedge clock) disable iff (reset)
      link_w[0].valid |-> $past(state_ff == S_ISSUE))
      else $error("operand entered cell row outside issue");

   a_last_is_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_row_ff == n_m1 && rsp_col_ff == n_m1)
      else $error("last flag on wrong element");
`endif

endmodule

// File: tb/testbench.sv
// Self-checking bench for integer_matrix_multiply: loads A and B over the req stream,
// predicts every product and checks the rsp stream against it. Needs imm_pkg and the RTL.
// Covers size settings 0 to 4 and 8 to 15 over APB, random idling on both sides and one long output stall.
`timescale 1ns / 1ps

module testbench;
   import imm_pkg::*;

   localparam int MAX_DIM   = MAX_DIM_DEF;
   localparam int CELLS     = MAX_DIM * MAX_DIM;
   localparam int PAD_W     = REQ_TDATA_W - 2 * IDX_W - DATA_W;
   localparam int DRAIN     = 2 * MAX_DIM + 8;
   localparam int SPARE_REG = 1;
   localparam int RAND_ITEMS = 360;
   localparam int LONG_HOLD = 500;
   localparam logic FUNC_A = 1'b0;
   localparam logic FUNC_B = 1'b1;

   typedef struct packed {
      logic                     func;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
      logic                     done;
   } load_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } product_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;  // row_index, col_index, element_value, pad
   logic                   req_tuser = 1'b0; // func
   logic                   req_tlast = 1'b0; // load_done
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // out_row, out_col, product_value, pad
   logic                   rsp_tlast;        // run_last
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]      csr_paddr = '0;
   logic [CSR_DW-1:0]      csr_pwdata = '0;
   logic [CSR_DW-1:0]      csr_prdata;
   logic                   csr_pready;

   // predictor state
   logic [DATA_W-1:0] a_mem [CELLS];
   logic [DATA_W-1:0] b_mem [CELLS];
   logic [SIZE_W-1:0] size_reg = SIZE_RESET;

   load_item_type pending [$];
   product_type   expected_products [$];

   // stimulus-side record of entries written since reset
   bit [CELLS-1:0] written_a = '0;
   bit [CELLS-1:0] written_b = '0;

   load_item_type drv_item;
   bit            offering = 1'b0;
   int            send_gap = 0;
   int            rsp_gap = 0;
   int            hold = 0;
   bit            long_hold_done = 1'b0;
   bit            no_idle = 1'b0;
   int            products_seen = 0;
   int            errors = 0;
   int            rand_items = 0;
   product_type   want;
   product_type   got;

   integer_matrix_multiply dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic int active_dim();
      int s;
      s = int'(size_reg);
      if (s < 1) s = 1;
      if (s > MAX_DIM) s = MAX_DIM;
      return s;
   endfunction

   // store the element, then on the final load queue the whole product matrix
   task automatic matmul_load(input load_item_type it);
      int n;
      logic [DATA_W-1:0] acc;
      product_type p;
      if (it.func == FUNC_A) a_mem[it.row * MAX_DIM + it.col] = it.value;
      else b_mem[it.row * MAX_DIM + it.col] = it.value;
      if (it.done) begin
         n = active_dim();
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               acc = '0;
               for (int k = 0; k < n; k++)
                  acc = acc + a_mem[r * MAX_DIM + k] * b_mem[k * MAX_DIM + c];
               p.row = IDX_W'(r);
               p.col = IDX_W'(c);
               p.value = acc;
               p.last = (r == n - 1) && (c == n - 1);
               expected_products.push_back(p);
            end
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            matmul_load(drv_item);
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending.size() > 0) begin
               drv_item = pending.pop_front();
               offering = 1'b1;
               send_gap = pick_gap();
            end
         end
         req_tvalid <= offering;
         req_tdata  <= {{PAD_W{1'b0}}, drv_item.value, drv_item.col, drv_item.row};
         req_tuser  <= drv_item.func;
         req_tlast  <= drv_item.done;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.row = rsp_tdata[IDX_W-1:0];
            got.col = rsp_tdata[2*IDX_W-1:IDX_W];
            got.value = rsp_tdata[2*IDX_W+DATA_W-1:2*IDX_W];
            got.last = rsp_tlast;
            if (expected_products.size() == 0) begin
               $error("unexpected product row %0d col %0d value %h",
                      got.row, got.col, got.value);
               errors++;
            end else begin
               want = expected_products.pop_front();
               if (got.row !== want.row) begin
                  $error("out_row: expected %0d, got %0d", want.row, got.row);
                  errors++;
               end
               if (got.col !== want.col) begin
                  $error("out_col: expected %0d, got %0d", want.col, got.col);
                  errors++;
               end
               if (got.value !== want.value) begin
                  $error("product_value: expected %h, got %h", want.value, got.value);
                  errors++;
               end
               if (got.last !== want.last) begin
                  $error("run_last: expected %0b, got %0b", want.last, got.last);
                  errors++;
               end
            end
            products_seen++;
            rsp_gap = pick_gap();
            if (!long_hold_done && products_seen >= 30 && pending.size() > 0) begin
               hold = LONG_HOLD;
               long_hold_done = 1'b1;
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input int index, input logic [CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'(index * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (index == int'(REG_MATRIX_SIZE)) size_reg = data[SIZE_W-1:0];
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending.size() > 0 || offering || expected_products.size() > 0)
         @(negedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic queue_load(input logic func, input int row, input int col,
                             input logic [DATA_W-1:0] value, input logic done);
      load_item_type it;
      it.func = func;
      it.row = IDX_W'(row);
      it.col = IDX_W'(col);
      it.value = value;
      it.done = done;
      if (func == FUNC_A) written_a[row * MAX_DIM + col] = 1'b1;
      else written_b[row * MAX_DIM + col] = 1'b1;
      pending.push_back(it);
   endtask

   function automatic logic [DATA_W-1:0] rand_element();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return DATA_W'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   // one loading run for an n x n product: every entry not yet written, a random part of
   // the rest, some stray loads, shuffled, then the final load
   task automatic queue_run(input int n);
      load_item_type run [$];
      load_item_type it;
      load_item_type tmp;
      int j;
      for (int f = 0; f < 2; f++) begin
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               if ((f == 0 && !written_a[r * MAX_DIM + c]) ||
                   (f == 1 && !written_b[r * MAX_DIM + c]) || $urandom_range(0, 1)) begin
                  it.func = f[0];
                  it.row = IDX_W'(r);
                  it.col = IDX_W'(c);
                  it.value = rand_element();
                  it.done = 1'b0;
                  run.push_back(it);
               end
            end
         end
      end
      repeat ($urandom_range(0, 3)) begin
         it.func = 1'($urandom_range(0, 1));
         it.row = IDX_W'($urandom_range(0, MAX_DIM - 1));
         it.col = IDX_W'($urandom_range(0, MAX_DIM - 1));
         it.value = rand_element();
         it.done = 1'b0;
         run.push_back(it);
      end
      for (int i = run.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = run[i];
         run[i] = run[j];
         run[j] = tmp;
      end
      foreach (run[i]) queue_load(run[i].func, int'(run[i].row), int'(run[i].col),
                                  run[i].value, 1'b0);
      queue_load(1'($urandom_range(0, 1)), $urandom_range(0, MAX_DIM - 1),
                 $urandom_range(0, MAX_DIM - 1), rand_element(), 1'b1);
      rand_items += run.size() + 1;
   endtask

   initial begin
      int phase;
      int sel;
      logic [CSR_DW-1:0] raw;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // size 0 behaves as 1; most negative squared wraps to zero
      csr_write(int'(REG_MATRIX_SIZE), 32'h0000_0000);
      queue_load(FUNC_A, 0, 0, 32'h8000_0000, 1'b0);
      queue_load(FUNC_B, 0, 0, 32'h8000_0000, 1'b1);
      queue_load(FUNC_A, 7, 7, 32'h1234_5678, 1'b0);
      queue_load(FUNC_B, 7, 7, 32'hFFFF_FFFF, 1'b0);
      queue_load(FUNC_A, 0, 0, 32'h7FFF_FFFF, 1'b1);
      wait_idle();

      // 2 x 2 with extreme elements, then a recompute over the kept stores
      csr_write(int'(REG_MATRIX_SIZE), 32'hFFFF_FFF2);
      queue_load(FUNC_A, 0, 1, 32'hFFFF_FFFF, 1'b0);
      queue_load(FUNC_A, 1, 0, 32'h7FFF_FFFF, 1'b0);
      queue_load(FUNC_A, 1, 1, 32'h8000_0000, 1'b0);
      queue_load(FUNC_B, 0, 1, 32'h7FFF_FFFF, 1'b0);
      queue_load(FUNC_B, 1, 0, 32'hFFFF_FFFF, 1'b0);
      queue_load(FUNC_B, 1, 1, 32'h8000_0000, 1'b0);
      queue_load(FUNC_B, 0, 0, 32'h0000_0001, 1'b0);
      queue_load(FUNC_A, 0, 0, 32'h0000_0000, 1'b1);
      queue_load(FUNC_A, 1, 1, 32'hFFFF_FFFF, 1'b1);
      wait_idle();

      // write to an unused register index: size stays 2
      csr_write(SPARE_REG, 32'h0000_0003);
      queue_load(FUNC_B, 1, 1, 32'h7FFF_FFFF, 1'b1);
      wait_idle();

      phase = 0;
      while (rand_items < RAND_ITEMS) begin
         sel = $urandom_range(0, 19);
         raw = $urandom;
         if (phase == 2) raw[SIZE_W-1:0] = 4'hF;
         else if (sel == 0) raw[SIZE_W-1:0] = 4'h0;
         else if (sel == 1) raw[SIZE_W-1:0] = 4'h8;
         else if (sel == 2) raw[SIZE_W-1:0] = SIZE_W'($urandom_range(9, 15));
         else raw[SIZE_W-1:0] = SIZE_W'($urandom_range(1, 4));
         csr_write(int'(REG_MATRIX_SIZE), raw);
         no_idle = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 4)) begin
            if (rand_items < RAND_ITEMS) queue_run(active_dim());
         end
         wait_idle();
         phase++;
      end
      no_idle = 1'b0;

      wait_idle();
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: integer_matrix_multiply.f
hw/rtl/imm_pkg.sv
hw/rtl/imm_cell.sv
hw/rtl/integer_matrix_multiply.sv
tb/testbench.sv
